/* hdl/lnr_pkg.sv */
// Shared constants and controller/datapath interface types for the row normaliser.
`timescale 1ns / 1ps
package lnr_pkg;

  // Row geometry
  localparam int ROW_LENGTH = 64;
  localparam int IDX_W      = $clog2(ROW_LENGTH);
  localparam int CNT_W      = $clog2(ROW_LENGTH + 1);

  // Arithmetic widths
  localparam int DATA_W = 32;
  localparam int SUM_W  = DATA_W + CNT_W + 1;
  localparam int SQ_W   = 31;
  localparam int DVD_W  = 64;
  localparam int ROOT_W = 24;
  localparam int DEV_W  = ROOT_W - 2;
  localparam int PA_W   = SUM_W + DATA_W;
  localparam int MEM_W  = 3 * DATA_W;

  // Divider step counter width
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mean_start;
    logic mean_take;
    logic prod_start;
    logic sqrt_start;
    logic elem_latch;
    logic elem_mul;
    logic elem_div_start;
    logic out_load;
    logic next_elem;
    logic row_clear;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cnt_last;
    logic div_done;
    logic prod_done;
    logic sqrt_done;
    logic out_free;
    logic elem_last;
  } ctl_stat_t;

endpackage

/* hdl/lnr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lnr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/lnr_div.sv */
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps
module lnr_div
  import lnr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEV_W-1:0] divisor,
  output logic [DVD_W-1:0] quot,
  output logic             done
);

  logic [DVD_W-1:0]     shq_r, shq_nxt;
  logic [DEV_W:0]       rem_r, rem_nxt;
  logic [DEV_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DEV_W+1:0]     rem_sh;

  // One shift-and-subtract step per cycle
  always_comb begin
    rem_sh   = {rem_r, shq_r[DVD_W-1]};
    shq_nxt  = shq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      shq_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {2'b00, dvs_r}) begin
        rem_nxt = (DEV_W + 1)'(rem_sh - {2'b00, dvs_r});
        shq_nxt = {shq_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEV_W:0];
        shq_nxt = {shq_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shq_r <= shq_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quot = shq_r;
  assign done = done_r;

endmodule

/* hdl/lnr_datapath.sv */
// Datapath: row storage, accumulators, mean/deviation units and per-element result path.
`timescale 1ns / 1ps
module lnr_datapath
  import lnr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  output ctl_stat_t         stat,
  input  logic [MEM_W-1:0]  in_tdata,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,
  output logic              out_tlast,
  output logic              out_tvalid
);

  // Accumulator and row state
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]          sq_r, sq_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [IDX_W-1:0]         k_r, k_nxt;
  logic signed [DATA_W-1:0] mean_r;

  logic signed [DATA_W-1:0]   x_in;
  logic signed [2*DATA_W-1:0] x_sq;
  logic [47:0]                sq_add;

  assign x_in   = in_tdata[DATA_W-1:0];
  assign x_sq   = x_in * x_in;
  assign sq_add = {17'b0, sq_r} + x_sq[63:16];

  always_comb begin
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    cnt_nxt = cnt_r;
    k_nxt   = k_r;
    if (cmd.row_clear) begin
      sum_nxt = '0;
      sq_nxt  = '0;
      cnt_nxt = '0;
      k_nxt   = '0;
    end else begin
      if (cmd.load) begin
        sum_nxt = sum_r + SUM_W'(x_in);
        sq_nxt  = (sq_add > 48'h7FFF_FFFF) ? '1 : sq_add[SQ_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
      end
      if (cmd.next_elem) begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sq_r  <= '0;
      cnt_r <= '0;
      k_r   <= '0;
    end else begin
      sum_r <= sum_nxt;
      sq_r  <= sq_nxt;
      cnt_r <= cnt_nxt;
      k_r   <= k_nxt;
    end
  end

  // Row store: {offset, gain, sample} per position
  logic [MEM_W-1:0] rd_data;

  lnr_ram #(.WIDTH(MEM_W), .DEPTH(ROW_LENGTH)) u_row_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_tdata),
    .raddr (k_r),
    .rdata (rd_data)
  );

  // Shared divider: mean = sum / N, then q = num / dev per element
  logic [SUM_W-1:0]        sum_mag;
  logic signed [64:0]      num_r;
  logic [64:0]             num_mag;
  logic [DVD_W-1:0]        div_dvd, div_quot;
  logic [DEV_W-1:0]        div_dvs, dev_w;
  logic                    div_done, qneg_r;
  logic signed [64:0]      q_s;

  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : sum_r;
  assign num_mag = num_r[64] ? 65'(-num_r) : num_r;
  assign div_dvd = cmd.mean_start ? DVD_W'(sum_mag) : num_mag[DVD_W-1:0];
  assign div_dvs = cmd.mean_start ? DEV_W'(cnt_r) : dev_w;

  lnr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mean_start | cmd.elem_div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quot     (div_quot),
    .done     (div_done)
  );

  assign q_s = qneg_r ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

  always_ff @(posedge clk) begin
    if (cmd.mean_start) begin
      qneg_r <= sum_r[SUM_W-1];
    end else if (cmd.elem_div_start) begin
      qneg_r <= num_r[64];
    end
    if (cmd.mean_take) begin
      mean_r <= q_s[DATA_W-1:0];
    end
  end

  // Serial shift-add multiply: |sum| * |mean|, one partial product per cycle
  logic [PA_W-1:0]   ma_r, acc_r;
  logic [DATA_W-1:0] mb_r;
  logic [DATA_W:0]   mean_mag;
  logic [5:0]        pcnt_r;
  logic              pbusy_r, pdone_r;

  assign mean_mag = mean_r[DATA_W-1] ? (DATA_W + 1)'(-$signed({mean_r[DATA_W-1], mean_r}))
                                     : {1'b0, mean_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pbusy_r <= 1'b0;
      pdone_r <= 1'b0;
      pcnt_r  <= '0;
    end else begin
      pdone_r <= 1'b0;
      if (cmd.prod_start) begin
        pbusy_r <= 1'b1;
        pcnt_r  <= '0;
      end else if (pbusy_r) begin
        pcnt_r <= pcnt_r + 1'b1;
        if (pcnt_r == 6'(DATA_W - 1)) begin
          pbusy_r <= 1'b0;
          pdone_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_start) begin
      ma_r  <= PA_W'(sum_mag);
      mb_r  <= mean_mag[DATA_W-1:0];
      acc_r <= '0;
    end else if (pbusy_r) begin
      if (mb_r[0]) begin
        acc_r <= acc_r + ma_r;
      end
      ma_r <= {ma_r[PA_W-2:0], 1'b0};
      mb_r <= {1'b0, mb_r[DATA_W-1:1]};
    end
  end

  // Variance: sumsq - floor(sum*mean / 2^16), clamped at zero
  logic [PA_W-17:0] prod_w;
  logic [SQ_W-1:0]  var_w;

  assign prod_w = acc_r[PA_W-1:16];
  assign var_w  = (prod_w >= (PA_W - 16)'(sq_r)) ? '0 : SQ_W'((PA_W - 16)'(sq_r) - prod_w);

  // Bit-pair square root of var * 2^16, one root bit per cycle
  logic [47:0]       rad_r;
  logic [ROOT_W+2:0] srem_r, srem_sh, strial;
  logic [ROOT_W-1:0] root_r;
  logic [4:0]        scnt_r;
  logic              sbusy_r, sdone_r;

  assign srem_sh = {srem_r[ROOT_W:0], rad_r[47:46]};
  assign strial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
      sdone_r <= 1'b0;
      scnt_r  <= '0;
    end else begin
      sdone_r <= 1'b0;
      if (cmd.sqrt_start) begin
        sbusy_r <= 1'b1;
        scnt_r  <= '0;
      end else if (sbusy_r) begin
        scnt_r <= scnt_r + 1'b1;
        if (scnt_r == 5'(ROOT_W - 1)) begin
          sbusy_r <= 1'b0;
          sdone_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad_r  <= {1'b0, var_w, 16'b0};
      srem_r <= '0;
      root_r <= '0;
    end else if (sbusy_r) begin
      rad_r <= {rad_r[45:0], 2'b00};
      if (srem_sh >= strial) begin
        srem_r <= srem_sh - strial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        srem_r <= srem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // dev = root/8 + 1
  assign dev_w = DEV_W'(root_r[ROOT_W-1:3]) + 1'b1;

  // Per-element path: difference, product with gain
  logic signed [DATA_W:0]   d_r;
  logic signed [DATA_W-1:0] gain_r, off_r, x_rd;

  assign x_rd = rd_data[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.elem_latch) begin
      d_r    <= {x_rd[DATA_W-1], x_rd} - {mean_r[DATA_W-1], mean_r};
      gain_r <= rd_data[2*DATA_W-1:DATA_W];
      off_r  <= rd_data[3*DATA_W-1:2*DATA_W];
    end
    if (cmd.elem_mul) begin
      num_r <= d_r * gain_r;
    end
  end

  // Offset add with saturation into the output register
  logic signed [65:0]       res_w;
  logic signed [DATA_W-1:0] sat_w;
  logic [DATA_W-1:0]        out_data_r;
  logic                     out_last_r, out_valid_r;
  logic                     elem_last;

  assign res_w = {q_s[64], q_s} + {{34{off_r[DATA_W-1]}}, off_r};

  always_comb begin
    if (res_w > 66'sh0_7FFF_FFFF) begin
      sat_w = 32'sh7FFF_FFFF;
    end else if (res_w < -66'sh0_8000_0000) begin
      sat_w = 32'sh8000_0000;
    end else begin
      sat_w = res_w[DATA_W-1:0];
    end
  end

  assign elem_last = (CNT_W'(k_r) + 1'b1) == cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= sat_w;
      out_last_r <= elem_last;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

  assign stat.cnt_last  = cnt_r == CNT_W'(ROW_LENGTH - 1);
  assign stat.div_done  = div_done;
  assign stat.prod_done = pdone_r;
  assign stat.sqrt_done = sdone_r;
  assign stat.out_free  = !out_valid_r || out_tready;
  assign stat.elem_last = elem_last;

endmodule

/* hdl/lnr_ctrl.sv */
// Controller: sequences row load, statistics, and per-element result generation.
`timescale 1ns / 1ps
module lnr_ctrl
  import lnr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tlast,
  output logic      in_tready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [12:0] {
    ST_LOAD      = 13'b0000000000001,
    ST_MEAN_GO   = 13'b0000000000010,
    ST_MEAN_WAIT = 13'b0000000000100,
    ST_PROD_GO   = 13'b0000000001000,
    ST_PROD_WAIT = 13'b0000000010000,
    ST_SQRT_GO   = 13'b0000000100000,
    ST_SQRT_WAIT = 13'b0000001000000,
    ST_RD        = 13'b0000010000000,
    ST_LATCH     = 13'b0000100000000,
    ST_MUL       = 13'b0001000000000,
    ST_DIV_GO    = 13'b0010000000000,
    ST_DIV_WAIT  = 13'b0100000000000,
    ST_OUT       = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast || stat.cnt_last) begin
            state_nxt = ST_MEAN_GO;
          end
        end
      end
      ST_MEAN_GO: begin
        cmd.mean_start = 1'b1;
        state_nxt      = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (stat.div_done) begin
          cmd.mean_take = 1'b1;
          state_nxt     = ST_PROD_GO;
        end
      end
      ST_PROD_GO: begin
        cmd.prod_start = 1'b1;
        state_nxt      = ST_PROD_WAIT;
      end
      ST_PROD_WAIT: begin
        if (stat.prod_done) begin
          state_nxt = ST_SQRT_GO;
        end
      end
      ST_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (stat.sqrt_done) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_LATCH;
      end
      ST_LATCH: begin
        cmd.elem_latch = 1'b1;
        state_nxt      = ST_MUL;
      end
      ST_MUL: begin
        cmd.elem_mul = 1'b1;
        state_nxt    = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.elem_div_start = 1'b1;
        state_nxt          = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.elem_last) begin
            cmd.row_clear = 1'b1;
            state_nxt     = ST_LOAD;
          end else begin
            cmd.next_elem = 1'b1;
            state_nxt     = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/layer_norm_row.sv */
// Top level of the row layer normaliser: controller plus datapath.
//
// Input stream (in_*): one request per row element carrying the sample, the
// gain and offset of its position; in_tlast closes the row. A row also closes
// on its 64th element. Requests are taken at one per cycle while a row loads.
// When the row closes the block computes the mean (shared divider), sum*mean
// (shift-add multiplier) and the deviation (square root), with in_tready low.
// It then produces one result per element, using the shared divider to form
// (x-mean)*gain/dev; in_tready stays low until the row's last result is loaded.
// Output stream (out_*): results leave through an output register; the next
// element is computed while a result waits, and the block holds the following
// one until out_tready frees the register. out_tlast marks the row's last result.
// Reset (rst_n low, synchronous) clears the controller, the accumulators and the
// output valid; the row store needs no clearing.
`timescale 1ns / 1ps
module layer_norm_row
  import lnr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [MEM_W-1:0]  in_tdata,   // sample [31:0], gain [63:32], offset [95:64]
  input  logic              in_tlast,   // row_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // normalized [31:0]
  output logic              out_tlast   // last_out
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  lnr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lnr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid)
  );

endmodule
